// ===== rtl/core/gf2m_pkg.sv =====
`default_nettype none
package gf2m_pkg;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned WordCount   = 10;
  localparam int unsigned FieldDegree = 293;
  localparam int unsigned FieldBits   = WordBits * WordCount;
  localparam int unsigned TopBits     = FieldDegree - (WordCount - 1) * WordBits;
  localparam int unsigned Tap1        = 11;
  localparam int unsigned Tap2        = 6;
  localparam int unsigned Tap3        = 1;

  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_MULT   = 3'd3,
    OP_SQR    = 3'd4,
    OP_TRACE  = 3'd5,
    OP_POW    = 3'd6,
    OP_INV    = 3'd7
  } op_e;

  // datapath commands from the controller
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic acc_xor;
    logic acc_one;
    logic acc_from_a;
    logic mul_start;   // begin bit-serial product acc * (b or a or acc)
    logic mul_sel_b;   // multiplier operand b
    logic mul_sel_acc; // multiplier operand accumulator (square)
    logic trace_xor;   // fold lsb of accumulator into trace
    logic trace_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/gf2m_polynomial_basis_alu_unit.sv =====
`default_nettype none
// gf2m alu, GF(2^293) polynomial basis mod x^293+x^11+x^6+x+1
// operations: loads return nothing; add, mult, sqr, pow and inverse return 10 words;
// trace runs 293 squarings and returns one word; pow up to 63 products; inverse 584
// each product runs one bit a cycle through the shift-and-add multiplier
// one request at a time: ready only while idle
// rst_ni async active low: operands, accumulator and controller clear to zero/idle
module gf2m_polynomial_basis_alu_unit #(
  parameter int unsigned FIELD_DEGREE = gf2m_pkg::FieldDegree
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // op[2:0], word_index[6:3], word_data[38:7], exponent[70:39]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // result_word[31:0], result_index[35:32]
  output logic             m_axis_tuser,   // trace_bit
  output logic             m_axis_tlast
);
  import gf2m_pkg::*;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic [FIELD_DEGREE-1:0] acc;
  logic [FieldBits-1:0]    acc_ext;
  logic                    trace;
  logic [3:0]              oidx;
  logic                    otrace;

  gf2m_ctrl #(.FIELD_DEGREE(FIELD_DEGREE)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[2:0]),
    .widx_i     (s_axis_tdata[6:3]),
    .exp_i      (s_axis_tdata[70:39]),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_idx_o  (oidx),
    .out_trace_o(otrace),
    .out_last_o (m_axis_tlast)
  );

  gf2m_datapath #(.FIELD_DEGREE(FIELD_DEGREE)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .widx_i (s_axis_tdata[6:3]),
    .wdata_i(s_axis_tdata[38:7]),
    .sts_o  (sts),
    .acc_o  (acc),
    .trace_o(trace)
  );

  assign acc_ext = FieldBits'(acc);
  // trace answer carries word zero
  assign m_axis_tdata = {4'd0, oidx, otrace ? 32'd0 : acc_ext[oidx*WordBits +: WordBits]};
  assign m_axis_tuser = otrace & trace;
endmodule
`default_nettype wire

// ===== rtl/core/gf2m_datapath.sv =====
`default_nettype none
module gf2m_datapath #(
  parameter int unsigned FIELD_DEGREE = gf2m_pkg::FieldDegree
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gf2m_pkg::dp_cmd_t   cmd_i,
  input  wire logic [3:0]          widx_i,
  input  wire logic [31:0]         wdata_i,
  output gf2m_pkg::dp_sts_t        sts_o,
  output logic [FIELD_DEGREE-1:0]  acc_o,
  output logic                     trace_o
);
  import gf2m_pkg::*;

  localparam int unsigned CntW = $clog2(FIELD_DEGREE + 1);
  localparam logic [FIELD_DEGREE-1:0] RedPoly =
    (FIELD_DEGREE'(1) << Tap1) | (FIELD_DEGREE'(1) << Tap2) |
    (FIELD_DEGREE'(1) << Tap3) | FIELD_DEGREE'(1);

  logic [FIELD_DEGREE-1:0] a_q, b_q, acc_q, acc_d;
  logic [FIELD_DEGREE-1:0] x_q, y_q, p_q, p_shift;
  logic [CntW-1:0]         cnt_q;
  logic                    busy_q, trace_q;
  logic [FIELD_DEGREE-1:0] wmask, wval;

  // word insert for loads, out-of-field bits drop naturally
  always_comb begin
    wmask = '0;
    wval  = '0;
    for (int i = 0; i < WordCount; i++) begin
      if (widx_i == 4'(i)) begin
        for (int j = 0; j < WordBits; j++) begin
          if (i * WordBits + j < FIELD_DEGREE) begin
            wmask[i*WordBits+j] = 1'b1;
            wval[i*WordBits+j]  = wdata_i[j];
          end
        end
      end
    end
  end

  // msb-first shift-and-add: p = p*x mod f, then add x if bit set
  assign p_shift = {p_q[FIELD_DEGREE-2:0], 1'b0} ^ (p_q[FIELD_DEGREE-1] ? RedPoly : '0);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_xor)         acc_d = a_q ^ b_q;
    else if (cmd_i.acc_one)    acc_d = FIELD_DEGREE'(1);
    else if (cmd_i.acc_from_a) acc_d = a_q;
    else if (busy_q && cnt_q == '0) acc_d = p_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; acc_q <= '0;
      busy_q <= 1'b0; cnt_q <= '0; trace_q <= 1'b0;
    end else begin
      if (cmd_i.load_a) a_q <= (a_q & ~wmask) | wval;
      if (cmd_i.load_b) b_q <= (b_q & ~wmask) | wval;
      acc_q <= acc_d;
      if (cmd_i.trace_clr) trace_q <= 1'b0;
      else if (cmd_i.trace_xor) trace_q <= trace_q ^ acc_q[0];
      if (cmd_i.mul_start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FIELD_DEGREE);
      end else if (busy_q) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      x_q <= acc_q;
      y_q <= cmd_i.mul_sel_acc ? acc_q : (cmd_i.mul_sel_b ? b_q : a_q);
      p_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      p_q <= p_shift ^ (y_q[FIELD_DEGREE-1] ? x_q : '0);
      y_q <= {y_q[FIELD_DEGREE-2:0], 1'b0};
    end
  end

  assign sts_o.mul_done = busy_q && cnt_q == '0;
  assign acc_o   = acc_q;
  assign trace_o = trace_q;
endmodule
`default_nettype wire

// ===== rtl/core/gf2m_ctrl.sv =====
`default_nettype none
module gf2m_ctrl #(
  parameter int unsigned FIELD_DEGREE = gf2m_pkg::FieldDegree
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [3:0]        widx_i,
  input  wire logic [31:0]       exp_i,
  input  wire gf2m_pkg::dp_sts_t sts_i,
  output gf2m_pkg::dp_cmd_t      cmd_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [3:0]             out_idx_o,
  output logic                   out_trace_o,
  output logic                   out_last_o
);
  import gf2m_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_MWAIT = 7'b0000100,
    S_SQR   = 7'b0001000,
    S_SWAIT = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_TOUT  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  op_e         op_q, op_d;
  logic [31:0] exp_q, exp_d;
  logic [8:0]  step_q, step_d;  // remaining exponent bits / trace or inverse rounds
  logic [3:0]  idx_q, idx_d;
  logic        accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q; op_d = op_q; exp_d = exp_q; step_d = step_q; idx_d = idx_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_e'(op_i);
          idx_d = '0;
          unique case (op_e'(op_i))
            OP_LOAD_A: cmd_o.load_a = widx_i < 4'(WordCount);
            OP_LOAD_B: cmd_o.load_b = widx_i < 4'(WordCount);
            OP_ADD: begin
              cmd_o.acc_xor = 1'b1;
              state_d = S_OUT;
            end
            OP_MULT: begin
              cmd_o.acc_from_a = 1'b1;
              state_d = S_MUL;
            end
            OP_SQR: begin
              cmd_o.acc_from_a = 1'b1;
              state_d = S_SQR;
            end
            OP_TRACE: begin
              // acc is reused as scratch; restored by squaring back fully
              cmd_o.acc_from_a = 1'b1;
              cmd_o.trace_clr  = 1'b1;
              step_d  = 9'(FIELD_DEGREE);
              state_d = S_SQR;
            end
            OP_POW: begin
              cmd_o.acc_one = 1'b1;
              exp_d  = exp_i;
              step_d = 9'd32;
              state_d = S_MUL;
            end
            OP_INV: begin
              cmd_o.acc_one = 1'b1;
              step_d  = 9'(FIELD_DEGREE - 1);
              state_d = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel_b = op_q == OP_MULT;
        if (op_q == OP_POW && !exp_q[31]) state_d = S_SQR;
        else state_d = S_MWAIT;
        if (op_q == OP_POW && !exp_q[31]) cmd_o.mul_start = 1'b0;
      end
      S_MWAIT: begin
        if (sts_i.mul_done) state_d = (op_q == OP_MULT) ? S_OUT : S_SQR;
      end
      S_SQR: begin
        // pow: skip final squaring
        if (op_q == OP_POW && step_q == 9'd1) state_d = S_OUT;
        else begin
          cmd_o.mul_start   = 1'b1;
          cmd_o.mul_sel_acc = 1'b1;
          cmd_o.trace_xor   = op_q == OP_TRACE;
          state_d = S_SWAIT;
        end
        if (op_q == OP_TRACE && step_q == '0) begin
          cmd_o = '0;
          state_d = S_TOUT;
        end
      end
      S_SWAIT: begin
        if (sts_i.mul_done) begin
          unique case (op_q)
            OP_SQR: state_d = S_OUT;
            OP_TRACE: begin
              step_d = step_q - 1'b1;
              state_d = S_SQR;
            end
            OP_POW: begin
              step_d = step_q - 1'b1;
              exp_d  = {exp_q[30:0], 1'b0};
              state_d = S_MUL;
            end
            OP_INV: begin
              // inverse ends on a squaring, exponent bit zero adds nothing
              step_d = step_q - 1'b1;
              state_d = (step_q == 9'd1) ? S_OUT : S_MUL;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == 4'(WordCount - 1)) state_d = S_IDLE;
        end
      end
      S_TOUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= OP_LOAD_A; exp_q <= '0; step_q <= '0; idx_q <= '0;
    end else begin
      state_q <= state_d; op_q <= op_d; exp_q <= exp_d; step_q <= step_d; idx_q <= idx_d;
    end
  end

  assign out_valid_o = state_q == S_OUT || state_q == S_TOUT;
  assign out_idx_o   = state_q == S_OUT ? idx_q : '0;
  assign out_trace_o = state_q == S_TOUT;
  assign out_last_o  = state_q == S_TOUT || idx_q == 4'(WordCount - 1);

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while results pending");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> idx_q < 4'(WordCount)) else $error("result index overrun");
  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_last_o |=> state_q == S_IDLE)
    else $error("no return to idle after last");
endmodule
`default_nettype wire

// ===== bench/gf2m_polynomial_basis_alu_unit_tb.sv =====
`timescale 1ns / 100ps

module gf2m_polynomial_basis_alu_unit_tb;
  import gf2m_pkg::*;

  localparam int unsigned Degree     = 293;
  localparam int unsigned CycleLimit = 4000000;

  typedef logic [Degree-1:0] elem_t;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        trace;
    logic        last;
  } result_t;

  // field model: keeps the operand registers and accumulator, queues result words
  class gf2m_scoreboard;
    logic [319:0] opnd_a;
    logic [319:0] opnd_b;
    elem_t        acc;
    result_t      pending[$];
    int           n_fail;
    int           n_words;
    int           n_requests;

    function new();
      opnd_a = '0;
      opnd_b = '0;
      acc = '0;
      n_fail = 0;
      n_words = 0;
      n_requests = 0;
    endfunction

    // carry-less product reduced by x^293+x^11+x^6+x+1
    function elem_t field_mul(elem_t x, elem_t y);
      logic [2*Degree-1:0] w;
      w = '0;
      for (int i = 0; i < Degree; i++)
        if (y[i]) w ^= {{Degree{1'b0}}, x} << i;
      for (int p = 2 * Degree - 1; p >= Degree; p--)
        if (w[p]) begin
          w[p] = 1'b0;
          w[p-Degree+11] ^= 1'b1;
          w[p-Degree+6] ^= 1'b1;
          w[p-Degree+1] ^= 1'b1;
          w[p-Degree] ^= 1'b1;
        end
      return w[Degree-1:0];
    endfunction

    function void push_acc();
      result_t r;
      for (int i = 0; i < 10; i++) begin
        r.word  = {acc, 27'd0} >> (32 * i + 27);
        r.index = 4'(i);
        r.trace = 1'b0;
        r.last  = (i == 9);
        pending.push_back(r);
      end
    endfunction

    function void note_request(op_e op, logic [3:0] idx, logic [31:0] data, logic [31:0] expo);
      elem_t   a;
      elem_t   t;
      logic    tr;
      result_t r;
      a = opnd_a[Degree-1:0];
      n_requests++;
      case (op)
        OP_LOAD_A, OP_LOAD_B: begin
          if (idx < 10) begin
            if (idx == 9) data &= 32'h1f;
            if (op == OP_LOAD_A) opnd_a[idx*32 +: 32] = data;
            else opnd_b[idx*32 +: 32] = data;
          end
        end
        OP_ADD:  begin acc = a ^ opnd_b[Degree-1:0]; push_acc(); end
        OP_MULT: begin acc = field_mul(a, opnd_b[Degree-1:0]); push_acc(); end
        OP_SQR:  begin acc = field_mul(a, a); push_acc(); end
        OP_TRACE: begin
          t = a;
          tr = 1'b0;
          for (int i = 0; i < Degree; i++) begin
            tr ^= t[0];
            t = field_mul(t, t);
          end
          r.word = '0; r.index = '0; r.trace = tr; r.last = 1'b1;
          pending.push_back(r);
        end
        OP_POW: begin
          // left-to-right square-and-multiply over all 32 exponent bits
          acc = elem_t'(1);
          for (int i = 31; i >= 0; i--) begin
            if (expo[i]) acc = field_mul(acc, a);
            if (i != 0) acc = field_mul(acc, acc);
          end
          push_acc();
        end
        default: begin
          // a^(2^293-2): exponent bits 292..1 set, bit 0 clear
          acc = elem_t'(1);
          for (int i = Degree - 1; i >= 1; i--) begin
            acc = field_mul(acc, a);
            acc = field_mul(acc, acc);
          end
          push_acc();
        end
      endcase
    endfunction

    function void check_result(logic [31:0] word, logic [3:0] idx, logic tr, logic lst);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h index %0d", word, idx);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      n_words++;
      if (word !== e.word) begin
        $error("result_word: expected %h actual %h", e.word, word); n_fail++;
      end
      if (idx !== e.index) begin
        $error("result_index: expected %0d actual %0d", e.index, idx); n_fail++;
      end
      if (tr !== e.trace) begin
        $error("trace_bit: expected %0b actual %0b", e.trace, tr); n_fail++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b actual %0b", e.last, lst); n_fail++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // op, word_index, word_data, exponent
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // result_word, result_index
  logic        m_axis_tuser;   // trace_bit
  logic        m_axis_tlast;

  gf2m_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int unsigned    cycles;

  gf2m_polynomial_basis_alu_unit u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // observe accepted requests and results
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(op_e'(s_axis_tdata[2:0]), s_axis_tdata[6:3], s_axis_tdata[38:7],
                      s_axis_tdata[70:39]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tuser, m_axis_tlast);
  end

  // receiver back-pressure
  always @(negedge clk_i)
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);

  task automatic send_request(op_e op, logic [3:0] idx, logic [31:0] data, logic [31:0] expo);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, expo, data, idx, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    int   r;
    op_e  op;
    logic [3:0] idx;
    logic [31:0] expo;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      expo = ($urandom_range(1)) ? $urandom : 32'($urandom_range(15));
      if (r < 70) op = $urandom_range(1) ? OP_LOAD_A : OP_LOAD_B;
      else if (r < 79) op = OP_ADD;
      else if (r < 88) op = OP_MULT;
      else if (r < 96) op = OP_SQR;
      else op = OP_POW;
      send_request(op, idx, $urandom, expo);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero operand right after reset: inverse of zero, power zero of zero
    send_request(OP_INV, 4'd0, 32'd0, 32'd0);
    send_request(OP_POW, 4'd0, 32'd0, 32'd0);
    // all-ones operand, top word gets trimmed to the field
    for (int i = 0; i < 10; i++) send_request(OP_LOAD_A, 4'(i), 32'hffff_ffff, 32'd0);
    send_request(OP_LOAD_B, 4'd0, 32'h8000_0001, 32'd0);
    send_request(OP_LOAD_B, 4'd9, 32'hffff_ffff, 32'd0);
    send_request(OP_LOAD_A, 4'd15, 32'd0, 32'd0);  // out of range, dropped
    send_request(OP_ADD, 4'd0, 32'd0, 32'd0);
    send_request(OP_MULT, 4'd0, 32'd0, 32'd0);
    send_request(OP_SQR, 4'd0, 32'd0, 32'd0);
    send_request(OP_TRACE, 4'd0, 32'd0, 32'd0);
    send_request(OP_POW, 4'd0, 32'd0, 32'hffff_ffff);
    send_request(OP_INV, 4'd0, 32'd0, 32'd0);

    // random phases with the four idling mixes
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(27);
    send_idle_pct = 45; recv_stall_pct = 0;  send_random(27);
    send_idle_pct = 0;  recv_stall_pct = 45; send_random(27);
    send_idle_pct = 28; recv_stall_pct = 28; send_random(27);
    s_axis_tvalid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d requests (loads, out-of-range loads, every operation)",
             sb.n_requests);
    $display("checked %0d result words under four idle/stall mixes", sb.n_words);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
